[rtl/tnop_pkg.sv]
// tnop_pkg: shared constants, types and the terminal-type request table
// for the telnet option parser
// depends on nothing
package tnop_pkg;

	localparam int SUB_KEEP_DEF = 4;
	localparam int NAWS_LEN     = 4;
	localparam int TTYPE_LEN    = 6;

	localparam logic [7:0] B_IAC  = 8'hFF;
	localparam logic [7:0] B_DONT = 8'hFE;
	localparam logic [7:0] B_DO   = 8'hFD;
	localparam logic [7:0] B_WONT = 8'hFC;
	localparam logic [7:0] B_WILL = 8'hFB;
	localparam logic [7:0] B_SB   = 8'hFA;
	localparam logic [7:0] B_SE   = 8'hF0;

	localparam logic [7:0] OPT_BINARY = 8'd0;
	localparam logic [7:0] OPT_ECHO   = 8'd1;
	localparam logic [7:0] OPT_SGA    = 8'd3;
	localparam logic [7:0] OPT_TTYPE  = 8'd24;
	localparam logic [7:0] OPT_NAWS   = 8'd31;
	localparam logic [7:0] QUAL_SEND  = 8'd1;

	localparam logic [15:0] COLS_RST = 16'd80;
	localparam logic [15:0] ROWS_RST = 16'd24;

	typedef enum logic [2:0] {
		ST_DATA,
		ST_IAC,
		ST_CMD,
		ST_SBOPT,
		ST_SBDATA,
		ST_SBIAC
	} parse_st_t;

	typedef enum logic [1:0] {
		CMD_WILL,
		CMD_WONT,
		CMD_DO,
		CMD_DONT
	} cmd_t;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_DATA,
		ACT_REPLY,
		ACT_TTYPE
	} act_t;

	typedef struct packed {
		logic       rd_en;
		logic       set_en;
		logic [7:0] opt;
	} map_req_t;

	function automatic logic [7:0] ttype_byte(input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0: r = B_IAC;
			3'd1: r = B_SB;
			3'd2: r = OPT_TTYPE;
			3'd3: r = QUAL_SEND;
			3'd4: r = B_IAC;
			default: r = B_SE;
		endcase
		return r;
	endfunction

endpackage

[rtl/tnop_replied_map.sv]
// tnop_replied_map: 256 x 1 map of options already answered, one
// synchronous read-modify-write port, swept clear after reset
// depends on tnop_pkg
module tnop_replied_map (
	input  logic                clk,
	input  logic                arst_n,
	input  tnop_pkg::map_req_t  req,
	output logic                rd_bit,
	output logic                busy
);

	logic       mem [256];
	logic       rd_bit_q;
	logic [7:0] clr_q;
	logic       busy_q;

	// read returns the old bit when the same entry is set in that cycle
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_bit_q <= mem[req.opt];
		end
		if (busy_q) begin
			mem[clr_q] <= 1'b0;
		end else if (req.set_en) begin
			mem[req.opt] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			clr_q <= clr_q + 8'd1;
			if (clr_q == 8'hFF) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign rd_bit = rd_bit_q;
	assign busy   = busy_q;

endmodule

[rtl/telnet_option_parser.sv]
// telnet_option_parser: top level of the telnet option negotiation parser
// depends on tnop_pkg and tnop_replied_map
//
// Received telnet bytes enter one per beat on s_axis; application data and
// reply bytes leave on m_axis, told apart by m_axis_tuser, with m_axis_tlast
// on the final beat caused by each input byte. A byte that gives results
// holds the input until its last result beat is loaded (one for data, three
// for an option reply not yet answered, six for the terminal-type request),
// so plain data flows at one byte per cycle while m_axis_tready stays high.
// The option map is a synchronous memory read as the option byte is taken;
// the reply decision waits on that registered read in the emit stage. After
// reset the map is swept clear, during which s_axis_tready stays low.
module telnet_option_parser #(
	parameter int SUB_KEEP = tnop_pkg::SUB_KEEP_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // in_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // out_byte, term_cols, term_rows, naws_on, zero pad
	output logic        m_axis_tlast,   // last
	output logic        m_axis_tuser    // kind
);

	localparam int CNT_W = $clog2(SUB_KEEP + 1);
	localparam int IDX_W = $clog2(SUB_KEEP);

	tnop_pkg::parse_st_t st_q, st_nxt;
	tnop_pkg::cmd_t      held_q;
	logic [7:0]          sopt_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [7:0]          sub_q [SUB_KEEP];
	logic [15:0]         cols_q, rows_q;
	logic                naws_q;

	logic [7:0]          b;
	logic                acc;
	logic                will;
	tnop_pkg::act_t      act;
	logic [7:0]          rep_cmd;
	logic                rd, set;
	logic                naws_set, naws_clr;
	logic                sub_wr, sopt_ld, win_ld, held_ld;
	tnop_pkg::map_req_t  req;
	logic                map_bit, busy;

	logic                valid_s1;
	tnop_pkg::act_t      act_s1;
	logic [7:0]          byte_s1;
	logic [7:0]          cmd_s1;
	logic [2:0]          idx_q;
	logic [2:0]          n;
	logic [7:0]          emit_byte;
	logic                out_free, load, is_last, done;

	logic                out_valid_q, out_kind_q, out_last_q, out_naws_q;
	logic [7:0]          out_byte_q;
	logic [15:0]         out_cols_q, out_rows_q;

	assign b   = s_axis_tdata;
	assign acc = s_axis_tvalid && s_axis_tready;
	assign will = (held_q == tnop_pkg::CMD_WILL) || (held_q == tnop_pkg::CMD_DO);

	// next parse state
	always_comb begin
		st_nxt = st_q;
		case (st_q)
			tnop_pkg::ST_DATA: begin
				if (b == tnop_pkg::B_IAC) st_nxt = tnop_pkg::ST_IAC;
			end
			tnop_pkg::ST_IAC: begin
				if (b inside {[tnop_pkg::B_WILL:tnop_pkg::B_DONT]}) begin
					st_nxt = tnop_pkg::ST_CMD;
				end else if (b == tnop_pkg::B_SB) begin
					st_nxt = tnop_pkg::ST_SBOPT;
				end else begin
					st_nxt = tnop_pkg::ST_DATA;
				end
			end
			tnop_pkg::ST_CMD:    st_nxt = tnop_pkg::ST_DATA;
			tnop_pkg::ST_SBOPT:  st_nxt = tnop_pkg::ST_SBDATA;
			tnop_pkg::ST_SBDATA: begin
				if (b == tnop_pkg::B_IAC) st_nxt = tnop_pkg::ST_SBIAC;
			end
			tnop_pkg::ST_SBIAC: begin
				if (b == tnop_pkg::B_IAC) st_nxt = tnop_pkg::ST_SBDATA;
				else st_nxt = tnop_pkg::ST_DATA;
			end
			default: st_nxt = tnop_pkg::ST_DATA;
		endcase
	end

	// per-byte decode
	always_comb begin
		act      = tnop_pkg::ACT_NONE;
		rep_cmd  = tnop_pkg::B_DO;
		rd       = 1'b0;
		set      = 1'b0;
		naws_set = 1'b0;
		naws_clr = 1'b0;
		sub_wr   = 1'b0;
		sopt_ld  = 1'b0;
		win_ld   = 1'b0;
		held_ld  = 1'b0;
		case (st_q)
			tnop_pkg::ST_DATA: begin
				if (b != tnop_pkg::B_IAC) act = tnop_pkg::ACT_DATA;
			end
			tnop_pkg::ST_IAC: begin
				if (b == tnop_pkg::B_IAC) begin
					act = tnop_pkg::ACT_DATA;
				end else if (b inside {[tnop_pkg::B_WILL:tnop_pkg::B_DONT]}) begin
					held_ld = 1'b1;
				end
			end
			tnop_pkg::ST_CMD: begin
				case (b)
					tnop_pkg::OPT_NAWS: begin
						if (will) begin
							naws_set = 1'b1;
							act      = tnop_pkg::ACT_REPLY;
							rep_cmd  = tnop_pkg::B_DO;
							rd       = 1'b1;
							set      = 1'b1;
						end else begin
							naws_clr = 1'b1;
						end
					end
					tnop_pkg::OPT_TTYPE: begin
						if (will) act = tnop_pkg::ACT_TTYPE;
					end
					tnop_pkg::OPT_BINARY, tnop_pkg::OPT_ECHO, tnop_pkg::OPT_SGA: begin
						act     = tnop_pkg::ACT_REPLY;
						rep_cmd = will ? tnop_pkg::B_DO : tnop_pkg::B_DONT;
						rd      = 1'b1;
						set     = 1'b1;
					end
					default: begin
						act     = tnop_pkg::ACT_REPLY;
						rep_cmd = will ? tnop_pkg::B_DONT : tnop_pkg::B_DO;
						rd      = 1'b1;
						set     = 1'b1;
					end
				endcase
			end
			tnop_pkg::ST_SBOPT: sopt_ld = 1'b1;
			tnop_pkg::ST_SBDATA: begin
				if (b != tnop_pkg::B_IAC) sub_wr = 1'b1;
			end
			tnop_pkg::ST_SBIAC: begin
				if (b == tnop_pkg::B_SE) begin
					win_ld = (sopt_q == tnop_pkg::OPT_NAWS) &&
						(cnt_q >= CNT_W'(tnop_pkg::NAWS_LEN));
				end else if (b == tnop_pkg::B_IAC) begin
					sub_wr = 1'b1;
				end
			end
			default: act = tnop_pkg::ACT_NONE;
		endcase
	end

	always_comb begin
		req.rd_en  = acc && rd;
		req.set_en = acc && set;
		req.opt    = b;
	end

	tnop_replied_map u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rd_bit (map_bit),
		.busy   (busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= tnop_pkg::ST_DATA;
			held_q <= tnop_pkg::CMD_WILL;
			sopt_q <= '0;
			cnt_q  <= '0;
			cols_q <= tnop_pkg::COLS_RST;
			rows_q <= tnop_pkg::ROWS_RST;
			naws_q <= 1'b0;
		end else if (acc) begin
			st_q <= st_nxt;
			if (held_ld) held_q <= tnop_pkg::cmd_t'(2'(b - tnop_pkg::B_WILL));
			if (sopt_ld) begin
				sopt_q <= b;
				cnt_q  <= '0;
			end
			if (sub_wr && (cnt_q < CNT_W'(SUB_KEEP))) cnt_q <= cnt_q + CNT_W'(1);
			if (win_ld) begin
				cols_q <= {sub_q[0], sub_q[1]};
				rows_q <= {sub_q[2], sub_q[3]};
			end
			if (naws_set) naws_q <= 1'b1;
			if (naws_clr) naws_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && sub_wr && (cnt_q < CNT_W'(SUB_KEEP))) begin
			sub_q[cnt_q[IDX_W-1:0]] <= b;
		end
	end

	// emit stage
	always_comb begin
		case (act_s1)
			tnop_pkg::ACT_DATA:  n = 3'd1;
			tnop_pkg::ACT_REPLY: n = map_bit ? 3'd0 : 3'd3;
			tnop_pkg::ACT_TTYPE: n = 3'(tnop_pkg::TTYPE_LEN);
			default:             n = 3'd0;
		endcase
	end

	always_comb begin
		case (act_s1)
			tnop_pkg::ACT_REPLY: begin
				if (idx_q == 3'd0) emit_byte = tnop_pkg::B_IAC;
				else if (idx_q == 3'd1) emit_byte = cmd_s1;
				else emit_byte = byte_s1;
			end
			tnop_pkg::ACT_TTYPE: emit_byte = tnop_pkg::ttype_byte(idx_q);
			default:             emit_byte = byte_s1;
		endcase
	end

	assign out_free      = !out_valid_q || m_axis_tready;
	assign load          = valid_s1 && (n != 3'd0) && out_free;
	assign is_last       = idx_q == (n - 3'd1);
	assign done          = valid_s1 && ((n == 3'd0) || (load && is_last));
	assign s_axis_tready = !busy && (!valid_s1 || done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) valid_s1 <= 1'b1;
			else if (done) valid_s1 <= 1'b0;
			if (done) idx_q <= '0;
			else if (load) idx_q <= idx_q + 3'd1;
			if (load) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			act_s1  <= act;
			byte_s1 <= b;
			cmd_s1  <= rep_cmd;
		end
		if (load) begin
			out_byte_q <= emit_byte;
			out_kind_q <= act_s1 != tnop_pkg::ACT_DATA;
			out_last_q <= is_last;
			out_cols_q <= cols_q;
			out_rows_q <= rows_q;
			out_naws_q <= naws_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_naws_q, out_rows_q, out_cols_q, out_byte_q};
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_kind_q;

endmodule

[rtl/tnop_checker.sv]
// tnop_checker: port-level assertions for telnet_option_parser
// bound to the top level; depends on nothing else
module tnop_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        m_axis_tuser
);

	// a data beat is always the only beat of its input byte
	a_data_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
		else $error("data beat without tlast");

	// map sweep keeps input closed straight after reset
	a_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !s_axis_tready)
		else $error("input open during map sweep");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output beat dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output beat changed while stalled");

endmodule

bind telnet_option_parser tnop_checker u_tnop_checker (.*);

[tb/tb_telnet_option_parser.sv]
// tb_telnet_option_parser: self-checking bench for the telnet option parser
// streams directed and random telnet byte sequences in and checks every output beat
// depends on tnop_pkg and the telnet_option_parser rtl
module tb_telnet_option_parser;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 400;
	localparam int PHASE_BYTES    = 50;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data;
		logic        last;
		logic [15:0] cols;
		logic [15:0] rows;
		logic        naws;
	} beat_t;

	class telnet_scoreboard;
		tnop_pkg::parse_st_t stage;
		tnop_pkg::cmd_t      held;
		logic [7:0]  sub_opt;
		logic [7:0]  sub_buf [tnop_pkg::SUB_KEEP_DEF];
		int          sub_cnt;
		bit          answered [256];
		logic [15:0] cols;
		logic [15:0] rows;
		logic        naws_agreed;
		logic [8:0]  burst [$];
		beat_t       pending [$];
		int          mismatches;
		int          beats_checked;
		int          size_updates;

		function new();
			stage = tnop_pkg::ST_DATA;
			held = tnop_pkg::CMD_WILL;
			sub_opt = 8'd0;
			sub_cnt = 0;
			foreach (answered[i]) answered[i] = 1'b0;
			cols = tnop_pkg::COLS_RST;
			rows = tnop_pkg::ROWS_RST;
			naws_agreed = 1'b0;
			mismatches = 0;
			beats_checked = 0;
			size_updates = 0;
		endfunction

		function void emit(logic kind, logic [7:0] val);
			burst.insert(burst.size(), {kind, val});
		endfunction

		// three-byte answer, suppressed once the option has been answered
		function void reply3(logic [7:0] cmd_b, logic [7:0] opt);
			if (answered[opt]) return;
			emit(1'b1, tnop_pkg::B_IAC);
			emit(1'b1, cmd_b);
			emit(1'b1, opt);
			answered[opt] = 1'b1;
		endfunction

		function void keep_sub(logic [7:0] val);
			if (sub_cnt < tnop_pkg::SUB_KEEP_DEF) begin
				sub_buf[sub_cnt] = val;
				sub_cnt++;
			end
		endfunction

		function void note_input(logic [7:0] val);
			logic [7:0] d;
			bit agree;
			beat_t e;
			burst.delete();
			case (stage)
				tnop_pkg::ST_DATA: begin
					if (val == tnop_pkg::B_IAC) stage = tnop_pkg::ST_IAC;
					else emit(1'b0, val);
				end
				tnop_pkg::ST_IAC: begin
					if (val == tnop_pkg::B_IAC) begin
						emit(1'b0, tnop_pkg::B_IAC);
						stage = tnop_pkg::ST_DATA;
					end else if (val >= tnop_pkg::B_WILL && val <= tnop_pkg::B_DONT) begin
						d = val - tnop_pkg::B_WILL;
						held = tnop_pkg::cmd_t'(d[1:0]);
						stage = tnop_pkg::ST_CMD;
					end else if (val == tnop_pkg::B_SB) begin
						stage = tnop_pkg::ST_SBOPT;
					end else begin
						stage = tnop_pkg::ST_DATA;
					end
				end
				tnop_pkg::ST_CMD: begin
					agree = (held == tnop_pkg::CMD_WILL || held == tnop_pkg::CMD_DO);
					case (val)
						tnop_pkg::OPT_NAWS: begin
							naws_agreed = agree;
							if (agree) reply3(tnop_pkg::B_DO, val);
						end
						tnop_pkg::OPT_TTYPE: begin
							if (agree) begin
								emit(1'b1, tnop_pkg::B_IAC);
								emit(1'b1, tnop_pkg::B_SB);
								emit(1'b1, tnop_pkg::OPT_TTYPE);
								emit(1'b1, tnop_pkg::QUAL_SEND);
								emit(1'b1, tnop_pkg::B_IAC);
								emit(1'b1, tnop_pkg::B_SE);
							end
						end
						tnop_pkg::OPT_BINARY, tnop_pkg::OPT_ECHO, tnop_pkg::OPT_SGA:
							reply3(agree ? tnop_pkg::B_DO : tnop_pkg::B_DONT, val);
						default: reply3(agree ? tnop_pkg::B_DONT : tnop_pkg::B_DO, val);
					endcase
					stage = tnop_pkg::ST_DATA;
				end
				tnop_pkg::ST_SBOPT: begin
					sub_opt = val;
					sub_cnt = 0;
					stage = tnop_pkg::ST_SBDATA;
				end
				tnop_pkg::ST_SBDATA: begin
					if (val == tnop_pkg::B_IAC) stage = tnop_pkg::ST_SBIAC;
					else keep_sub(val);
				end
				tnop_pkg::ST_SBIAC: begin
					if (val == tnop_pkg::B_SE) begin
						if (sub_opt == tnop_pkg::OPT_NAWS && sub_cnt >= tnop_pkg::NAWS_LEN) begin
							cols = {sub_buf[0], sub_buf[1]};
							rows = {sub_buf[2], sub_buf[3]};
							size_updates++;
						end
						stage = tnop_pkg::ST_DATA;
					end else if (val == tnop_pkg::B_IAC) begin
						keep_sub(tnop_pkg::B_IAC);
						stage = tnop_pkg::ST_SBDATA;
					end else begin
						stage = tnop_pkg::ST_DATA;
					end
				end
				default: stage = tnop_pkg::ST_DATA;
			endcase
			foreach (burst[i]) begin
				e.kind = burst[i][8];
				e.data = burst[i][7:0];
				e.last = (i == burst.size() - 1);
				e.cols = cols;
				e.rows = rows;
				e.naws = naws_agreed;
				pending.insert(pending.size(), e);
			end
		endfunction

		function void check_result(beat_t got);
			beat_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: kind %0d byte %02h last %0d cols %0d rows %0d naws %0d",
						got.kind, got.data, got.last, got.cols, got.rows, got.naws);
				return;
			end
			want = pending.pop_front();
			beats_checked++;
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("beat %0d expected: kind %0d byte %02h last %0d cols %0d rows %0d naws %0d",
						beats_checked, want.kind, want.data, want.last, want.cols, want.rows,
						want.naws);
					$display("beat %0d actual:   kind %0d byte %02h last %0d cols %0d rows %0d naws %0d",
						beats_checked, got.kind, got.data, got.last, got.cols, got.rows, got.naws);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_valid = 1'b0;
	logic        s_ready;
	logic [7:0]  s_data = 8'd0;
	logic        m_valid;
	logic        m_ready = 1'b0;
	logic [47:0] m_data;
	logic        m_last;
	logic        m_user;

	int   tx_idle_pct = 34;
	int   rx_idle_pct = 47;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int   hold_left = 0;
	int   quiet_cycles = 0;
	int   bytes_sent = 0;
	beat_t seen;
	telnet_scoreboard sb = new();

	telnet_option_parser u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.s_axis_tdata  (s_data),   // in_byte
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_data),   // out_byte, term_cols, term_rows, naws_on, zero pad
		.m_axis_tlast  (m_last),   // last
		.m_axis_tuser  (m_user)    // kind
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// output side: random stalls plus one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
			m_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_ready <= 1'b0;
		end else begin
			m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_valid && m_ready) begin
				seen.kind = m_user;
				seen.data = m_data[7:0];
				seen.last = m_last;
				seen.cols = m_data[23:8];
				seen.rows = m_data[39:24];
				seen.naws = m_data[40];
				sb.check_result(seen);
			end
			if ((s_valid && s_ready) || (m_valid && m_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat moved for %0d cycles", quiet_cycles);
				$display("end of test: mismatches");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic send_byte(input logic [7:0] val);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_valid <= 1'b0;
			@(posedge clk);
		end
		s_valid <= 1'b1;
		s_data <= val;
		@(posedge clk);
		while (!s_ready) @(posedge clk);
		sb.note_input(val);
		bytes_sent++;
	endtask

	task automatic send_option();
		case ($urandom_range(0, 7))
			0: send_byte(tnop_pkg::OPT_BINARY);
			1: send_byte(tnop_pkg::OPT_ECHO);
			2: send_byte(tnop_pkg::OPT_SGA);
			3: send_byte(tnop_pkg::OPT_TTYPE);
			4, 5: send_byte(tnop_pkg::OPT_NAWS);
			default: send_byte(8'($urandom_range(0, 255)));
		endcase
	endtask

	task automatic random_sequence();
		int pick;
		int n;
		int tail;
		logic [7:0] val;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			send_byte(8'($urandom_range(0, 254)));
		end else if (pick < 38) begin
			send_byte(tnop_pkg::B_IAC);
			send_byte(tnop_pkg::B_IAC);
		end else if (pick < 63) begin
			send_byte(tnop_pkg::B_IAC);
			send_byte(tnop_pkg::B_WILL + 8'($urandom_range(0, 3)));
			send_option();
		end else if (pick < 88) begin
			send_byte(tnop_pkg::B_IAC);
			send_byte(tnop_pkg::B_SB);
			n = $urandom_range(0, 9);
			if (n < 6) send_byte(tnop_pkg::OPT_NAWS);
			else if (n == 6) send_byte(tnop_pkg::OPT_TTYPE);
			else send_byte(8'($urandom_range(0, 255)));
			n = $urandom_range(0, 6);
			repeat (n) begin
				val = 8'($urandom_range(0, 255));
				send_byte(val);
				if (val == tnop_pkg::B_IAC) send_byte(tnop_pkg::B_IAC);
			end
			tail = $urandom_range(0, 9);
			if (tail < 8) begin
				send_byte(tnop_pkg::B_IAC);
				send_byte(tnop_pkg::B_SE);
			end else if (tail == 8) begin
				// abandon the subnegotiation
				send_byte(tnop_pkg::B_IAC);
				send_byte(8'($urandom_range(0, 239)));
			end
		end else if (pick < 95) begin
			send_byte(tnop_pkg::B_IAC);
			send_byte(8'($urandom_range(0, 249)));
		end else begin
			send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic run_phase(input int tx_pct, input int rx_pct, input bit long_hold);
		int start;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		if (long_hold) hold_req <= 1'b1;
		start = bytes_sent;
		while (bytes_sent - start < PHASE_BYTES) random_sequence();
		s_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		logic [7:0] directed [$];
		directed = '{8'h00, tnop_pkg::B_IAC, tnop_pkg::B_IAC, tnop_pkg::B_IAC, tnop_pkg::B_SE,
			tnop_pkg::B_IAC, tnop_pkg::B_DO, tnop_pkg::OPT_TTYPE,
			tnop_pkg::B_IAC, tnop_pkg::B_DONT, 8'h05,
			tnop_pkg::B_IAC, tnop_pkg::B_WILL, tnop_pkg::OPT_NAWS,
			tnop_pkg::B_IAC, tnop_pkg::B_SB, tnop_pkg::OPT_NAWS, 8'h01, 8'h00,
			tnop_pkg::B_IAC, tnop_pkg::B_IAC, 8'h30, 8'h12, tnop_pkg::B_IAC, tnop_pkg::B_SE,
			tnop_pkg::B_IAC, tnop_pkg::B_WONT, tnop_pkg::OPT_NAWS};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_byte(directed[i]);
		s_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);

		run_phase(34, 47, 1'b0);
		run_phase(47, 34, 1'b0);
		run_phase(0, 0, 1'b1);

		repeat (20) @(posedge clk);
		$display("sent %0d telnet bytes: data, escapes, option commands, subnegotiations",
			bytes_sent);
		$display("checked %0d output beats, %0d window size updates, %0d mismatches",
			sb.beats_checked, sb.size_updates, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

[telnet_option_parser.f]
rtl/tnop_pkg.sv
rtl/tnop_replied_map.sv
rtl/telnet_option_parser.sv
rtl/tnop_checker.sv
tb/tb_telnet_option_parser.sv
